[rtl/core/mtbig_pkg.sv]
// mtbig_pkg: shared types and constants for the bounded mt19937 generator
// no dependencies
package mtbig_pkg;

    localparam int unsigned N_WORDS  = 624;
    localparam int unsigned M_OFFSET = 397;
    localparam int unsigned IDX_W    = 10;

    localparam logic [31:0] MAT_A        = 32'h9908b0df;
    localparam logic [31:0] HI_MASK      = 32'h80000000;
    localparam logic [31:0] LO_MASK      = 32'h7fffffff;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_BOUND  = 2'd1;
    localparam logic [1:0] CFG_NEGATE = 2'd2;

    typedef enum logic [0:0] {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } op_t;

    // classified command passed through the queue
    typedef struct packed {
        op_t         op;
        logic [31:0] seed;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_WR,
        ST_TW_RD0,
        ST_TW_RD1,
        ST_TW_RD2,
        ST_TW_WR,
        ST_DRAW_RD,
        ST_DRAW_WAIT,
        ST_DRAW_TEMPER,
        ST_EMIT
    } back_state_t;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // bit length of a 31-bit bound, 0..31
    function automatic logic [5:0] bit_len(input logic [30:0] a);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 31; i++)
        begin
            if (a[i])
            begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

[rtl/core/mtbig_front.sv]
// mtbig_front: input stage, classifies beats and holds them in a two-entry queue
// depends on mtbig_pkg
module mtbig_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [31:0]      seed,
    output logic             cmd_valid,
    output mtbig_pkg::cmd_t  cmd,
    input  logic             cmd_take
);

    mtbig_pkg::cmd_t q_reg [2];
    logic [1:0] count_reg;
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic       push;
    logic       pop;

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].op   <= kind ? mtbig_pkg::OP_RESEED : mtbig_pkg::OP_DRAW;
            q_reg[wr_ptr_reg].seed <= seed;
        end
    end

endmodule

[rtl/core/mtbig_back.sv]
// mtbig_back: state store, seeding, in-place twist, tempering and rejection
// depends on mtbig_pkg
module mtbig_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  mtbig_pkg::cmd_t  cmd,
    output logic             cmd_take,
    input  logic             output_mode,
    input  logic [30:0]      bound_value,
    input  logic             negate,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [32:0]      value
);

    localparam int unsigned IW = mtbig_pkg::IDX_W;
    localparam logic [IW-1:0] LAST = IW'(mtbig_pkg::N_WORDS - 1);
    localparam logic [IW-1:0] NW   = IW'(mtbig_pkg::N_WORDS);

    mtbig_pkg::back_state_t state_reg, state_next;

    logic [31:0]   mem [mtbig_pkg::N_WORDS];
    logic [31:0]   rdata_reg;
    logic [IW-1:0] raddr;
    logic          we;
    logic [IW-1:0] waddr;
    logic [31:0]   wdata;

    logic [IW-1:0] words_left_reg;
    logic          seeded_reg;
    logic [IW-1:0] read_index_reg;
    logic [IW-1:0] k_reg;
    logic [31:0]   prev_reg;
    logic [31:0]   prod_reg;
    logic [31:0]   cur_reg;
    logic [31:0]   nxt_reg;
    logic [31:0]   y_reg;
    logic [32:0]   value_reg;
    logic          pending_reseed_reg;
    logic [5:0]    shift;
    logic [31:0]   shifted;
    logic          need_twist;
    logic [IW-1:0] k_next1;
    logic [IW-1:0] k_far;
    logic [IW:0]   far_sum;
    logic [31:0]   mix;
    logic [31:0]   tw_word;

    assign shift     = 6'd32 - mtbig_pkg::bit_len(bound_value);
    assign shifted   = y_reg >> shift;
    assign need_twist = (words_left_reg == IW'(1)) || !seeded_reg;
    assign k_next1   = (k_reg == LAST) ? '0 : k_reg + IW'(1);
    assign far_sum   = {1'b0, k_reg} + (IW + 1)'(mtbig_pkg::M_OFFSET);
    assign k_far     = (far_sum >= {1'b0, NW}) ? IW'(far_sum - {1'b0, NW}) : far_sum[IW-1:0];
    assign mix       = (cur_reg & mtbig_pkg::HI_MASK) | (nxt_reg & mtbig_pkg::LO_MASK);
    assign tw_word   = rdata_reg ^ (mix >> 1) ^ (nxt_reg[0] ? mtbig_pkg::MAT_A : 32'd0);
    assign out_valid = (state_reg == mtbig_pkg::ST_EMIT);
    assign value     = value_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtbig_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == mtbig_pkg::OP_RESEED)
                    begin
                        state_next = mtbig_pkg::ST_SEED_WR;
                    end
                    else if (output_mode && bound_value == '0)
                    begin
                        state_next = mtbig_pkg::ST_EMIT;
                    end
                    else if (!seeded_reg)
                    begin
                        state_next = mtbig_pkg::ST_SEED_WR;
                    end
                    else if (need_twist)
                    begin
                        state_next = mtbig_pkg::ST_TW_RD0;
                    end
                    else
                    begin
                        state_next = mtbig_pkg::ST_DRAW_RD;
                    end
                end
            end
            mtbig_pkg::ST_SEED_MUL:  state_next = mtbig_pkg::ST_SEED_WR;
            mtbig_pkg::ST_SEED_WR:
            begin
                if (k_reg != LAST)
                begin
                    state_next = mtbig_pkg::ST_SEED_MUL;
                end
                else if (pending_reseed_reg)
                begin
                    state_next = mtbig_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mtbig_pkg::ST_TW_RD0;
                end
            end
            mtbig_pkg::ST_TW_RD0:    state_next = mtbig_pkg::ST_TW_RD1;
            mtbig_pkg::ST_TW_RD1:    state_next = mtbig_pkg::ST_TW_RD2;
            mtbig_pkg::ST_TW_RD2:    state_next = mtbig_pkg::ST_TW_WR;
            mtbig_pkg::ST_TW_WR:
            begin
                state_next = (k_reg == LAST) ? mtbig_pkg::ST_DRAW_RD : mtbig_pkg::ST_TW_RD0;
            end
            mtbig_pkg::ST_DRAW_RD:   state_next = mtbig_pkg::ST_DRAW_WAIT;
            mtbig_pkg::ST_DRAW_WAIT: state_next = mtbig_pkg::ST_DRAW_TEMPER;
            mtbig_pkg::ST_DRAW_TEMPER:
            begin
                if (!output_mode || shifted <= {1'b0, bound_value})
                begin
                    state_next = mtbig_pkg::ST_EMIT;
                end
                else if (need_twist)
                begin
                    state_next = mtbig_pkg::ST_TW_RD0;
                end
                else
                begin
                    state_next = mtbig_pkg::ST_DRAW_RD;
                end
            end
            mtbig_pkg::ST_EMIT:
            begin
                if (!out_stall)
                begin
                    state_next = mtbig_pkg::ST_IDLE;
                end
            end
            default: state_next = mtbig_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_take = 1'b0;
        we       = 1'b0;
        waddr    = k_reg;
        wdata    = prod_reg;
        raddr    = read_index_reg;
        unique case (state_reg)
            mtbig_pkg::ST_IDLE:   cmd_take = cmd_valid;
            mtbig_pkg::ST_SEED_WR:
            begin
                we = 1'b1;
            end
            mtbig_pkg::ST_TW_RD0: raddr = k_reg;
            mtbig_pkg::ST_TW_RD1: raddr = k_next1;
            mtbig_pkg::ST_TW_RD2: raddr = k_far;
            mtbig_pkg::ST_TW_WR:
            begin
                we    = 1'b1;
                wdata = tw_word;
            end
            default:
            begin
                raddr = read_index_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= mtbig_pkg::ST_IDLE;
            words_left_reg     <= IW'(1);
            seeded_reg         <= 1'b0;
            read_index_reg     <= '0;
            k_reg              <= '0;
            pending_reseed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                mtbig_pkg::ST_IDLE:
                begin
                    k_reg <= '0;
                    if (cmd_valid)
                    begin
                        pending_reseed_reg <= (cmd.op == mtbig_pkg::OP_RESEED);
                    end
                end
                mtbig_pkg::ST_SEED_WR:
                begin
                    if (k_reg == LAST)
                    begin
                        k_reg          <= '0;
                        seeded_reg     <= 1'b1;
                        words_left_reg <= IW'(1);
                    end
                    else
                    begin
                        k_reg <= k_reg + IW'(1);
                    end
                end
                mtbig_pkg::ST_TW_WR:
                begin
                    if (k_reg == LAST)
                    begin
                        k_reg          <= '0;
                        // the draw that follows the twist takes one count back off
                        words_left_reg <= NW + IW'(1);
                        read_index_reg <= '0;
                    end
                    else
                    begin
                        k_reg <= k_reg + IW'(1);
                    end
                end
                mtbig_pkg::ST_DRAW_RD:
                begin
                    words_left_reg <= words_left_reg - IW'(1);
                    read_index_reg <= (read_index_reg == LAST) ? '0 : read_index_reg + IW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mtbig_pkg::ST_IDLE:
            begin
                prod_reg <= (cmd.op == mtbig_pkg::OP_RESEED) ? cmd.seed
                                                              : mtbig_pkg::DEFAULT_SEED;
                value_reg <= '0;
            end
            mtbig_pkg::ST_SEED_WR:
            begin
                prev_reg <= prod_reg;
            end
            mtbig_pkg::ST_SEED_MUL:
            begin
                prod_reg <= mtbig_pkg::SEED_MULT * (prev_reg ^ (prev_reg >> 30))
                            + {22'd0, k_reg};
            end
            mtbig_pkg::ST_TW_RD1: cur_reg <= rdata_reg;
            mtbig_pkg::ST_TW_RD2: nxt_reg <= rdata_reg;
            mtbig_pkg::ST_DRAW_WAIT: y_reg <= mtbig_pkg::temper(rdata_reg);
            mtbig_pkg::ST_DRAW_TEMPER:
            begin
                if (!output_mode)
                begin
                    value_reg <= {1'b0, y_reg};
                end
                else if (negate)
                begin
                    value_reg <= 33'd0 - {1'b0, shifted};
                end
                else
                begin
                    value_reg <= {1'b0, shifted};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/core/mt19937_bounded_integer_generator.sv]
// mt19937_bounded_integer_generator: top level, config registers plus front and back parts
// depends on mtbig_pkg, mtbig_front, mtbig_back
//
// Mersenne twister (mt19937) generator with raw and bounded modes. A command beat
// with kind=1 reseeds the 624-word state, one word at a time through the registered
// seeding multiply; kind=0 draws one value and returns one beat. A draw from a live
// state reads one word of the state memory and tempers it before the output beat;
// every 624th word triggers an in-place twist, three reads and one write per word,
// through the same memory, and a never-seeded block seeds with 5489 first. Bounded
// mode rejects shifted words above the bound, averaging under two draws. A two-entry
// queue separates the input side from the engine, so commands are taken while a
// result waits. Config writes are always ready.
module mt19937_bounded_integer_generator
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         kind,
    input  logic [31:0]  seed,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [32:0]  value,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic            output_mode_reg;
    logic [30:0]     bound_value_reg;
    logic            negate_reg;
    logic            cmd_valid;
    logic            cmd_take;
    mtbig_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    // config register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_mode_reg <= 1'b0;
            bound_value_reg <= '0;
            negate_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mtbig_pkg::CFG_MODE:   output_mode_reg <= cfg_data[0];
                mtbig_pkg::CFG_BOUND:  bound_value_reg <= cfg_data[30:0];
                mtbig_pkg::CFG_NEGATE: negate_reg      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    mtbig_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .seed      (seed),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    mtbig_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take),
        .output_mode (output_mode_reg),
        .bound_value (bound_value_reg),
        .negate      (negate_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value)
    );

endmodule
